// ----- src/rtspfr_pkg.sv -----
`timescale 1ns / 1ps

package rtspfr_pkg;

    localparam int FRAME_BITS   = 56;
    localparam int PULSE_W      = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int BIT_CNT_W    = 6;
    localparam int HW_CNT_W     = 3;

    localparam logic [HW_CNT_W-1:0]  HW_CNT_SAT = 3'd7;
    localparam logic [BIT_CNT_W-1:0] FRAME_LEN  = 6'd56;
    localparam logic [7:0]           NIB_LO     = 8'h0F;
    localparam logic [7:0]           NIB_HI     = 8'hF0;

    // rx_status codes
    localparam logic [1:0] ST_SYNC = 2'd0;
    localparam logic [1:0] ST_DATA = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HW_SYNC_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HW_SYNC_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SW_SYNC_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SW_SYNC_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SYMBOL_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SYMBOL_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SYMBOL_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SYMBOL_MAX = 3'd7;

    // register reset values
    localparam logic [PULSE_W-1:0] RST_HW_SYNC_MIN     = 16'd1792;
    localparam logic [PULSE_W-1:0] RST_HW_SYNC_MAX     = 16'd3328;
    localparam logic [PULSE_W-1:0] RST_SW_SYNC_MIN     = 16'd3584;
    localparam logic [PULSE_W-1:0] RST_SW_SYNC_MAX     = 16'd6656;
    localparam logic [PULSE_W-1:0] RST_HALF_SYMBOL_MIN = 16'd448;
    localparam logic [PULSE_W-1:0] RST_HALF_SYMBOL_MAX = 16'd832;
    localparam logic [PULSE_W-1:0] RST_FULL_SYMBOL_MIN = 16'd896;
    localparam logic [PULSE_W-1:0] RST_FULL_SYMBOL_MAX = 16'd1664;

    typedef struct packed {
        logic [PULSE_W-1:0] hw_sync_min;
        logic [PULSE_W-1:0] hw_sync_max;
        logic [PULSE_W-1:0] sw_sync_min;
        logic [PULSE_W-1:0] sw_sync_max;
        logic [PULSE_W-1:0] half_symbol_min;
        logic [PULSE_W-1:0] half_symbol_max;
        logic [PULSE_W-1:0] full_symbol_min;
        logic [PULSE_W-1:0] full_symbol_max;
    } timing_cfg_t;

    typedef struct packed {
        logic hw_sync;
        logic sw_sync;
        logic half_symbol;
        logic full_symbol;
    } pulse_class_t;

    typedef struct packed {
        logic [3:0]  command_code;
        logic        command_known;
        logic [7:0]  key_byte;
        logic [15:0] seq_counter;
        logic [23:0] remote_address;
        logic        checksum_ok;
    } frame_fields_t;

endpackage

// ----- src/rtspfr_classifier.sv -----
`timescale 1ns / 1ps

module rtspfr_classifier
    import rtspfr_pkg::*;
(
    input  logic [PULSE_W-1:0] pulse,
    input  timing_cfg_t        cfg,
    output pulse_class_t       cls
);

    // strict bounds on both sides
    assign cls.hw_sync     = (pulse > cfg.hw_sync_min) && (pulse < cfg.hw_sync_max);
    assign cls.sw_sync     = (pulse > cfg.sw_sync_min) && (pulse < cfg.sw_sync_max);
    assign cls.half_symbol = (pulse > cfg.half_symbol_min) && (pulse < cfg.half_symbol_max);
    assign cls.full_symbol = (pulse > cfg.full_symbol_min) && (pulse < cfg.full_symbol_max);

endmodule

// ----- src/rtspfr_frame_decode.sv -----
`timescale 1ns / 1ps

module rtspfr_frame_decode
    import rtspfr_pkg::*;
(
    input  logic [FRAME_BITS-1:0] payload,
    output frame_fields_t         fields
);

    logic [7:0] raw [7];
    logic [7:0] dec [7];
    logic [7:0] ck;
    logic [3:0] cmd;

    always_comb
    begin
        for (int i = 0; i < 7; i++)
        begin
            raw[i] = payload[FRAME_BITS-1-8*i -: 8];
        end
        // undo the chaining: each byte was XORed with the previous raw byte
        dec[0] = raw[0];
        for (int i = 1; i < 7; i++)
        begin
            dec[i] = raw[i] ^ raw[i-1];
        end
        ck = 8'd0;
        for (int i = 0; i < 7; i++)
        begin
            ck = ck ^ dec[i] ^ {4'd0, dec[i][7:4]};
        end
        ck = ck & NIB_LO;
    end

    assign cmd = 4'((dec[1] & NIB_HI) >> 4);

    assign fields.command_code   = cmd;
    assign fields.command_known  = (cmd <= 4'd6) || (cmd == 4'd8) || (cmd == 4'd9)
                                   || (cmd == 4'd10);
    assign fields.key_byte       = dec[0];
    assign fields.seq_counter    = {dec[2], dec[3]};
    assign fields.remote_address = {dec[6], dec[5], dec[4]};
    assign fields.checksum_ok    = (ck == 8'd0);

endmodule

// ----- src/rts_pulse_frame_receiver_unit.sv -----
`timescale 1ns / 1ps

// Pulse-length frame receiver. Each input beat is one measured level length in
// microseconds; each beat yields exactly one result beat with the receive status,
// a running pulse count and, on the pulse that completes a 56-bit frame, the
// decoded command, key byte, rolling counter, address and checksum flag. A beat
// passes the input register, then the result register; a beat is taken each cycle
// unless a stalled result beat holds the input register. The state update for a
// beat happens as it moves on. The user must write timing windows through the
// cfg port while no beat is in flight; the block itself does not enforce this.
module rts_pulse_frame_receiver_unit
    import rtspfr_pkg::*;
#(
    parameter int MIN_HW_SYNC_PULSES = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PULSE_W-1:0]   cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PULSE_W-1:0]   pulse_length,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           rx_status,
    output logic [3:0]           command_code,
    output logic                 command_known,
    output logic [7:0]           key_byte,
    output logic [15:0]          seq_counter,
    output logic [23:0]          remote_address,
    output logic                 checksum_ok,
    output logic [15:0]          pulse_count
);

    localparam logic [HW_CNT_W-1:0] MIN_HW = HW_CNT_W'(MIN_HW_SYNC_PULSES);

    timing_cfg_t cfg_reg;

    logic               in_vld_reg;
    logic [PULSE_W-1:0] pulse_reg;
    logic               advance;
    logic               in_accept;

    logic                  receiving_reg,  receiving_next;
    logic [HW_CNT_W-1:0]   hw_cnt_reg,     hw_cnt_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg,    bit_cnt_next;
    logic                  last_bit_reg,   last_bit_next;
    logic                  half_pend_reg,  half_pend_next;
    logic [FRAME_BITS-1:0] payload_reg,    payload_next;
    logic [15:0]           pulses_reg,     pulses_next;
    logic                  done;

    logic          out_vld_reg;
    logic [1:0]    status_reg;
    frame_fields_t fields_reg;
    logic [15:0]   count_reg;

    pulse_class_t  cls;
    frame_fields_t fields;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hw_sync_min     <= RST_HW_SYNC_MIN;
            cfg_reg.hw_sync_max     <= RST_HW_SYNC_MAX;
            cfg_reg.sw_sync_min     <= RST_SW_SYNC_MIN;
            cfg_reg.sw_sync_max     <= RST_SW_SYNC_MAX;
            cfg_reg.half_symbol_min <= RST_HALF_SYMBOL_MIN;
            cfg_reg.half_symbol_max <= RST_HALF_SYMBOL_MAX;
            cfg_reg.full_symbol_min <= RST_FULL_SYMBOL_MIN;
            cfg_reg.full_symbol_max <= RST_FULL_SYMBOL_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HW_SYNC_MIN:     cfg_reg.hw_sync_min     <= cfg_data;
                REG_HW_SYNC_MAX:     cfg_reg.hw_sync_max     <= cfg_data;
                REG_SW_SYNC_MIN:     cfg_reg.sw_sync_min     <= cfg_data;
                REG_SW_SYNC_MAX:     cfg_reg.sw_sync_max     <= cfg_data;
                REG_HALF_SYMBOL_MIN: cfg_reg.half_symbol_min <= cfg_data;
                REG_HALF_SYMBOL_MAX: cfg_reg.half_symbol_max <= cfg_data;
                REG_FULL_SYMBOL_MIN: cfg_reg.full_symbol_min <= cfg_data;
                REG_FULL_SYMBOL_MAX: cfg_reg.full_symbol_max <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // handshake: input register moves on whenever the result register is free
    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && out_vld_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pulse_reg <= pulse_length;
        end
    end

    rtspfr_classifier u_classifier (
        .pulse (pulse_reg),
        .cfg   (cfg_reg),
        .cls   (cls)
    );

    // per-pulse receive state update
    always_comb
    begin
        receiving_next = receiving_reg;
        hw_cnt_next    = hw_cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        last_bit_next  = last_bit_reg;
        half_pend_next = half_pend_reg;
        payload_next   = payload_reg;

        if (!receiving_reg)
        begin
            priority if (cls.hw_sync)
            begin
                if (hw_cnt_reg != HW_CNT_SAT)
                begin
                    hw_cnt_next = hw_cnt_reg + 1'b1;
                end
            end
            else if (cls.sw_sync && (hw_cnt_reg >= MIN_HW))
            begin
                bit_cnt_next   = '0;
                last_bit_next  = 1'b0;
                half_pend_next = 1'b0;
                payload_next   = '0;
                receiving_next = 1'b1;
            end
            else
            begin
                hw_cnt_next = '0;
            end
        end
        else
        begin
            priority if (!half_pend_reg && cls.full_symbol)
            begin
                // full symbol: level flips, push the new bit
                last_bit_next = !last_bit_reg;
                payload_next  = {payload_reg[FRAME_BITS-2:0], !last_bit_reg};
                bit_cnt_next  = bit_cnt_reg + 1'b1;
            end
            else if (cls.half_symbol)
            begin
                if (half_pend_reg)
                begin
                    half_pend_next = 1'b0;
                    payload_next   = {payload_reg[FRAME_BITS-2:0], last_bit_reg};
                    bit_cnt_next   = bit_cnt_reg + 1'b1;
                end
                else
                begin
                    half_pend_next = 1'b1;
                end
            end
            else
            begin
                // abort back to sync
                hw_cnt_next    = '0;
                receiving_next = 1'b0;
            end
        end

        done = receiving_next && (bit_cnt_next >= FRAME_LEN);
        if (done)
        begin
            receiving_next = 1'b0;
            pulses_next    = '0;
        end
        else
        begin
            pulses_next = pulses_reg + 1'b1;
        end
    end

    rtspfr_frame_decode u_frame_decode (
        .payload (payload_next),
        .fields  (fields)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            hw_cnt_reg    <= '0;
            bit_cnt_reg   <= '0;
            last_bit_reg  <= 1'b0;
            half_pend_reg <= 1'b0;
            payload_reg   <= '0;
            pulses_reg    <= '0;
        end
        else if (advance)
        begin
            receiving_reg <= receiving_next;
            hw_cnt_reg    <= hw_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            last_bit_reg  <= last_bit_next;
            half_pend_reg <= half_pend_next;
            payload_reg   <= payload_next;
            pulses_reg    <= pulses_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (done)
            begin
                status_reg <= ST_DONE;
                fields_reg <= fields;
            end
            else
            begin
                status_reg <= receiving_next ? ST_DATA : ST_SYNC;
                fields_reg <= '0;
            end
            count_reg <= pulses_next;
        end
    end

    assign out_valid      = out_vld_reg;
    assign rx_status      = status_reg;
    assign command_code   = fields_reg.command_code;
    assign command_known  = fields_reg.command_known;
    assign key_byte       = fields_reg.key_byte;
    assign seq_counter    = fields_reg.seq_counter;
    assign remote_address = fields_reg.remote_address;
    assign checksum_ok    = fields_reg.checksum_ok;
    assign pulse_count    = count_reg;

endmodule

// ----- src/rtspfr_checker.sv -----
`timescale 1ns / 1ps

module rtspfr_checker
    import rtspfr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  rx_status,
    input logic [3:0]  command_code,
    input logic        command_known,
    input logic [7:0]  key_byte,
    input logic [15:0] seq_counter,
    input logic [23:0] remote_address,
    input logic        checksum_ok,
    input logic [15:0] pulse_count
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rx_status)
            && $stable(pulse_count) && $stable(remote_address))
        else $error("stalled result beat changed");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rx_status == ST_SYNC) || (rx_status == ST_DATA)
            || (rx_status == ST_DONE))
        else $error("illegal rx_status");

    // frame fields are only nonzero on a completed frame
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rx_status != ST_DONE) |-> (command_code == 4'd0)
            && !command_known && (key_byte == 8'd0) && (seq_counter == 16'd0)
            && (remote_address == 24'd0) && !checksum_ok)
        else $error("frame fields set without a complete frame");

    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rx_status == ST_DONE) |-> (pulse_count == 16'd0))
        else $error("pulse count not cleared on frame completion");

endmodule

bind rts_pulse_frame_receiver_unit rtspfr_checker u_rtspfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .rx_status      (rx_status),
    .command_code   (command_code),
    .command_known  (command_known),
    .key_byte       (key_byte),
    .seq_counter    (seq_counter),
    .remote_address (remote_address),
    .checksum_ok    (checksum_ok),
    .pulse_count    (pulse_count)
);
